// ===== design/iclm_pkg.sv =====
`default_nettype none

package iclm_pkg;

    // Window tick counter and configuration register width
    localparam int unsigned TICK_W       = 16;
    localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd10;

    // Quotient digits: two for the whole part, two for the hundredths
    localparam int unsigned DIGIT_W      = 4;
    localparam int unsigned PCT_W        = 7;
    localparam int unsigned DIGIT_CNT_W  = 2;
    localparam int unsigned STEP_CNT_W   = 2;

    typedef struct packed {
        logic tick;
        logic idle_pulse;
    } t_in_item;

    typedef struct packed {
        logic [PCT_W-1:0] usage_whole;
        logic [PCT_W-1:0] usage_hundredths;
        logic             recalibrated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCALE,
        ST_STEP,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== design/idle_based_cpu_load_meter.sv =====
`default_nettype none

// Channel   Signals                          Direction  Payload
// input     i_valid / o_ready / i_data       in         t_in_item (tick, idle_pulse)
// result    o_valid / i_ready / o_data       out        t_out_item (whole, hundredths, recal)
// config    i_cfg_wr_en / i_cfg_wr_data      in         window_ticks, no wait
//
// An item that does not close a window leaves the block ready for the next one. A
// closing item with a lower count than the capacity raises o_valid after a compare
// state, then four decimal digits, each formed by a times-ten step and four
// restoring subtract steps on the shared subtractor. A recalibrating window goes
// from the compare state straight to raising o_valid. Inputs are
// held off while a result is being formed or waits for i_ready. Reset is
// synchronous, active low, and sets the window length to ten ticks.

module idle_based_cpu_load_meter #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire iclm_pkg::t_in_item  i_data,
    output logic                     o_valid,
    input  wire                      i_ready,
    output iclm_pkg::t_out_item      o_data,
    input  wire                      i_cfg_wr_en,
    input  wire [iclm_pkg::TICK_W-1:0] i_cfg_wr_data
);

    import iclm_pkg::*;

    localparam int unsigned REM_W = COUNT_WIDTH + DIGIT_W;

    t_state                  r_state, n_state;
    logic [TICK_W-1:0]       r_window_ticks;
    logic [TICK_W-1:0]       r_ticks;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [COUNT_WIDTH-1:0]  r_cap;
    logic [REM_W-1:0]        r_rem;
    logic [REM_W-1:0]        r_dvs;
    logic [DIGIT_W-2:0]      r_q;
    logic [DIGIT_W-1:0]      r_acc;
    logic [DIGIT_CNT_W-1:0]  r_digit;
    logic [STEP_CNT_W-1:0]   r_step;
    logic [PCT_W-1:0]        r_whole;
    logic [PCT_W-1:0]        r_hund;
    logic                    r_recal;

    logic                    in_take;
    logic [TICK_W-1:0]       ticks_inc;
    logic [TICK_W-1:0]       limit;
    logic                    win_close;
    logic                    below_cap;
    logic                    sub_ge;
    logic [DIGIT_W-1:0]      digit;
    logic [PCT_W-1:0]        pair_val;

    // Decode the window end for the item on the input
    always_comb begin
        in_take   = i_valid && (r_state == ST_IDLE);
        ticks_inc = r_ticks + TICK_W'(1);
        limit     = (r_window_ticks == '0) ? TICK_W'(1) : r_window_ticks;
        win_close = i_data.tick && ((ticks_inc == '0) || (ticks_inc >= limit));
        below_cap = r_count < r_cap;
        sub_ge    = r_rem >= r_dvs;
        digit     = {r_q, sub_ge};
        pair_val  = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1) + {3'b000, digit};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && win_close) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = below_cap ? ST_SCALE : ST_OUT;
            end
            ST_SCALE: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (r_step == '1) begin
                    n_state = (r_digit == '1) ? ST_OUT : ST_SCALE;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs and result payload
    always_comb begin
        o_ready                 = (r_state == ST_IDLE);
        o_valid                 = (r_state == ST_OUT);
        o_data.usage_whole      = r_whole;
        o_data.usage_hundredths = r_hund;
        o_data.recalibrated     = r_recal;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_window_ticks <= WINDOW_RESET;
            r_ticks        <= '0;
            r_count        <= '0;
            r_cap          <= '0;
            r_digit        <= '0;
            r_step         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_window_ticks <= i_cfg_wr_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        // Count the pulse, holding at full scale
                        if (i_data.idle_pulse && !(&r_count)) begin
                            r_count <= r_count + COUNT_WIDTH'(1);
                        end
                        if (i_data.tick) begin
                            r_ticks <= win_close ? '0 : ticks_inc;
                        end
                    end
                end
                ST_CHECK: begin
                    // Raise the capacity when this window was at least as idle
                    if (!below_cap) begin
                        r_cap <= r_count;
                    end
                    r_count <= '0;
                    r_digit <= '0;
                    r_step  <= '0;
                end
                ST_STEP: begin
                    r_step <= r_step + STEP_CNT_W'(1);
                    if (r_step == '1) begin
                        r_digit <= r_digit + DIGIT_CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Divider datapath: one decimal digit per pass, one quotient bit per step
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CHECK: begin
                r_rem   <= REM_W'(r_cap - r_count);
                r_whole <= '0;
                r_hund  <= '0;
                r_recal <= !below_cap;
            end
            ST_SCALE: begin
                r_rem <= (r_rem << 3) + (r_rem << 1);
                r_dvs <= {r_cap, {DIGIT_W{1'b0}}} >> 1;
            end
            ST_STEP: begin
                if (sub_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_dvs <= r_dvs >> 1;
                r_q   <= digit[DIGIT_W-2:0];
                if (r_step == '1) begin
                    // Even digits are tens, odd digits close a two-digit pair
                    if (!r_digit[0]) begin
                        r_acc <= digit;
                    end else if (!r_digit[1]) begin
                        r_whole <= pair_val;
                    end else begin
                        r_hund <= pair_val;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== verif/idle_based_cpu_load_meter_test.sv =====
module idle_based_cpu_load_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iclm_pkg::*;

    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned PERCENT       = 100;
    localparam int unsigned TOTAL_ITEMS   = 1850;
    localparam int unsigned MAX_GAP       = 11;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam logic [TICK_W-1:0] WINDOW_MAX = '1;

    // Predict busy percentage per closed window and hold expected results
    class usage_scoreboard;
        logic [TICK_W-1:0]  window_len;
        logic [COUNT_W-1:0] capacity;
        logic [COUNT_W-1:0] idle_total;
        logic [TICK_W-1:0]  tick_total;
        t_out_item          expected_usage[$];
        int unsigned        errors;

        function new();
            window_len = WINDOW_RESET;
            capacity   = '0;
            idle_total = '0;
            tick_total = '0;
            errors     = 0;
        endfunction

        function void set_window(logic [TICK_W-1:0] value);
            window_len = value;
        endfunction

        // Note one accepted input transaction; queue a result if it closes a window
        function void note_transaction(t_in_item item);
            logic [TICK_W-1:0] limit;
            logic [63:0]       scaled;
            logic [63:0]       quot;
            logic [63:0]       frac;
            t_out_item         want;
            if (item.idle_pulse && idle_total != '1) begin
                idle_total = idle_total + 1'b1;
            end
            if (!item.tick) return;
            limit = (window_len == '0) ? TICK_W'(1) : window_len;
            tick_total = tick_total + 1'b1;
            if (tick_total != '0 && tick_total < limit) return;
            want = '0;
            if (idle_total < capacity) begin
                scaled = 64'(capacity - idle_total) * PERCENT;
                quot   = scaled / capacity;
                frac   = ((scaled % capacity) * PERCENT) / capacity;
                want.usage_whole      = quot[PCT_W-1:0];
                want.usage_hundredths = frac[PCT_W-1:0];
            end else begin
                // Recalibrate: capacity follows this window's count
                capacity = idle_total;
                want.recalibrated = 1'b1;
            end
            idle_total = '0;
            tick_total = '0;
            expected_usage.push_back(want);
        endfunction

        // Compare one accepted result transaction with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_usage.size() == 0) begin
                $display("%0t: unexpected result whole %0d hund %0d recal %0d", $time,
                         got.usage_whole, got.usage_hundredths, got.recalibrated);
                errors++;
                return;
            end
            want = expected_usage.pop_front();
            if (got !== want) begin
                $display("%0t: usage mismatch expected whole %0d hund %0d recal %0d, actual whole %0d hund %0d recal %0d",
                         $time, want.usage_whole, want.usage_hundredths, want.recalibrated,
                         got.usage_whole, got.usage_hundredths, got.recalibrated);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_in_item          i_data;
    logic              o_valid;
    logic              i_ready;
    t_out_item         o_data;
    logic              i_cfg_wr_en;
    logic [TICK_W-1:0] i_cfg_wr_data;

    usage_scoreboard   sb;
    bit                gaps_on;
    int unsigned       items_sent;
    int unsigned       stall_cycles;

    idle_based_cpu_load_meter #(
        .COUNT_WIDTH (COUNT_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    // Monitor both channels and guard against a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_result(o_data);
            end
            if (i_valid && o_ready) begin
                sb.note_transaction(i_data);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offer one input transaction after a random gap; leave valid high on return
    task automatic send_sample(input logic tick, input logic pulse);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data.tick <= tick;
        i_data.idle_pulse <= pulse;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Take results with a random hold-off before each one
    task automatic accept_usage();
        int unsigned gap;
        forever begin
            gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    endtask

    // Wait for all outstanding results, then let any work in flight settle
    task automatic drain_phase();
        while (sb.expected_usage.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [TICK_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        sb.set_window(value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Random items with a tick rate and an idle density that drifts over the phase
    task automatic run_phase(input int unsigned n_items, input int unsigned tick_odds);
        int unsigned pulse_pct;
        pulse_pct = $urandom_range(100, 0);
        for (int unsigned k = 0; k < n_items; k++) begin
            if ($urandom_range(15, 0) == 0) begin
                pulse_pct = $urandom_range(100, 0);
            end
            send_sample($urandom_range(tick_odds - 1, 0) == 0,
                        $urandom_range(99, 0) < pulse_pct);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int unsigned pick;
        logic [TICK_W-1:0] window;
        sb = new();
        gaps_on = 1'b0;
        items_sent = 0;
        stall_cycles = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_ready <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            accept_usage();
        join_none

        // Reset window length with no idle pulses: empty calibration
        repeat (10) send_sample(1'b1, 1'b0);
        i_valid <= 1'b0;
        drain_phase();

        // Zero window length closes on every tick; closing pulse counts
        gaps_on = 1'b1;
        write_window('0);
        repeat (3) send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        i_valid <= 1'b0;
        drain_phase();

        // Longest window: ticks accumulate without closing
        write_window(WINDOW_MAX);
        repeat (3) send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        i_valid <= 1'b0;
        drain_phase();

        // Shorten below the ticks already seen: next tick closes
        write_window(TICK_W'(2));
        send_sample(1'b1, 1'b0);
        i_valid <= 1'b0;
        drain_phase();

        // Random phases over a spread of window lengths
        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(19, 0);
            if (pick == 0) begin
                window = WINDOW_MAX;
            end else if (pick == 1) begin
                window = '0;
            end else if (pick <= 3) begin
                window = TICK_W'($urandom_range(300, 20));
            end else begin
                window = TICK_W'($urandom_range(12, 1));
            end
            gaps_on = $urandom_range(3, 0) != 0;
            write_window(window);
            run_phase((pick == 0) ? 15 : $urandom_range(150, 40), $urandom_range(4, 1));
            drain_phase();
        end

        if (sb.errors == 0 && sb.expected_usage.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== idle_based_cpu_load_meter.f =====
design/iclm_pkg.sv
design/idle_based_cpu_load_meter.sv
verif/idle_based_cpu_load_meter_test.sv
